// ===== hw/rtl/tpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_pkg
// Types and constants shared by the tile map pixel lookup block.
// ----------------------------------------------------------------------------
package tpl_pkg;

   localparam int PIX_W     = 16;   // pixel and origin coordinates
   localparam int DIFF_W    = 17;   // pixel minus origin, signed
   localparam int SIZE_W    = 11;   // tile size registers
   localparam int GRID_W    = 7;    // grid size registers
   localparam int LOCAL_W   = 10;   // coordinate inside a tile
   localparam int INDEX_W   = 29;   // tile index field of a cell word
   localparam int WORD_W    = 32;   // cell word
   localparam int CELL_W    = 6;    // write column and row
   localparam int CSR_AW    = 5;    // byte address of the register file
   localparam int CSR_DW    = 32;

   // cell word flag positions
   localparam int FLAG_X_BIT = 31;
   localparam int FLAG_Y_BIT = 30;
   localparam int FLAG_D_BIT = 29;

   // register indexes (word address bits)
   localparam logic [2:0] REG_TILE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_TILE_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_GRID_COLUMNS = 3'd2;
   localparam logic [2:0] REG_GRID_ROWS    = 3'd3;
   localparam logic [2:0] REG_ORIGIN_X     = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Y     = 3'd5;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [CELL_W-1:0]        cell_col;
      logic [CELL_W-1:0]        cell_row;
      logic [WORD_W-1:0]        cell_word;
      logic signed [PIX_W-1:0]  pixel_x;
      logic signed [PIX_W-1:0]  pixel_y;
   } req_beat_type;

   typedef struct packed {
      logic                     write_ok;
      logic                     hit;
      logic [INDEX_W-1:0]       tile_index;
      logic [LOCAL_W-1:0]       local_u;
      logic [LOCAL_W-1:0]       local_v;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]        tile_width;
      logic [SIZE_W-1:0]        tile_height;
      logic [GRID_W-1:0]        grid_columns;
      logic [GRID_W-1:0]        grid_rows;
      logic signed [PIX_W-1:0]  origin_x;
      logic signed [PIX_W-1:0]  origin_y;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SETUP,
      ST_DIVIDE,
      ST_CHECK,
      ST_READ,
      ST_FLIP
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tilemap_pixel_lookup_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilemap_pixel_lookup_core
// Tile map store with pixel lookup, flip flags and diagonal swap.
//
//   channel   ports                         handshake
//   request   start, busy, req_data         taken when start & !busy
//   result    rsp_strobe, rsp_data          one-cycle strobe, no back-pressure
//   config    psel..pready (APB-style)      write on psel&penable&pwrite
//
// a write item keeps busy high through its write state; a lookup runs
// setup, the two bit-serial dividers side by side, range check, memory
// read and flip; a lookup that misses before dividing ends after setup
// the result strobe comes in the cycle after the last busy cycle
// after reset a clearing pass zeroes the store, one word a cycle, all
// MAX_COLUMNS*MAX_ROWS words (4096 by default), with busy high
// register writes are taken at all times
// ----------------------------------------------------------------------------
module tilemap_pixel_lookup_core #(
   parameter int MAX_COLUMNS   = 64,
   parameter int MAX_ROWS      = 64,
   parameter int MAX_TILE_SIDE = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire tpl_pkg::req_beat_type      req_data,
   output logic                            rsp_strobe,
   output tpl_pkg::rsp_type                rsp_data,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [tpl_pkg::CSR_AW-1:0] paddr,
   input  wire logic [tpl_pkg::CSR_DW-1:0] pwdata,
   output logic      [tpl_pkg::CSR_DW-1:0] prdata,
   output logic                            pready
);
   import tpl_pkg::*;

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cfg_type              cfg;
   state_type            state_ff, state_in;
   req_beat_type         req_ff, req_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 inside_ff, inside_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic [SIZE_W-1:0]    tw, th, cols, rows;
   logic signed [DIFF_W-1:0] dx, dy;
   logic                 early_miss;
   logic                 write_fits;
   logic                 div_load;
   logic                 div_done;
   logic                 div_done_y;
   logic [PIX_W-1:0]     quo_x, quo_y;
   logic [LOCAL_W-1:0]   rem_x, rem_y;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic [WORD_W-1:0]    word;
   logic [SIZE_W-1:0]    su, sv;
   logic                 swap;
   logic                 clr_last;

   tpl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // effective sizes after clamping to the build limits
   assign tw   = (cfg.tile_width > SIZE_W'(MAX_TILE_SIDE)) ? SIZE_W'(MAX_TILE_SIDE)
                                                           : cfg.tile_width;
   assign th   = (cfg.tile_height > SIZE_W'(MAX_TILE_SIDE)) ? SIZE_W'(MAX_TILE_SIDE)
                                                            : cfg.tile_height;
   assign cols = (SIZE_W'(cfg.grid_columns) > SIZE_W'(MAX_COLUMNS)) ? SIZE_W'(MAX_COLUMNS)
                                                                   : SIZE_W'(cfg.grid_columns);
   assign rows = (SIZE_W'(cfg.grid_rows) > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS)
                                                             : SIZE_W'(cfg.grid_rows);

   assign dx = DIFF_W'(req_ff.pixel_x) - DIFF_W'(cfg.origin_x);
   assign dy = DIFF_W'(req_ff.pixel_y) - DIFF_W'(cfg.origin_y);
   assign early_miss = dx[DIFF_W-1] | dy[DIFF_W-1] | (tw == '0) | (th == '0);

   assign write_fits = (SIZE_W'(req_ff.cell_col) < cols) & (SIZE_W'(req_ff.cell_row) < rows);

   assign div_load = (state_ff == ST_SETUP) & ~early_miss;

   tpl_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (dx[PIX_W-1:0]),
      .divisor   (tw),
      .done      (div_done),
      .quotient  (quo_x),
      .remainder (rem_x)
   );

   tpl_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .load      (div_load),
      .dividend  (dy[PIX_W-1:0]),
      .divisor   (th),
      .done      (div_done_y),
      .quotient  (quo_y),
      .remainder (rem_y)
   );

   tpl_cell_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (addr_ff),
      .rd_data (word)
   );

   assign clr_last = clr_ff == AW'(DEPTH - 1);
   assign busy     = state_ff != ST_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               state_in = (req_data.req_type == REQ_LOOKUP) ? ST_SETUP : ST_WRITE;
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_SETUP:  state_in = early_miss ? ST_IDLE : ST_DIVIDE;
         ST_DIVIDE: if (div_done & div_done_y) state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_READ;
         ST_READ:   state_in = ST_FLIP;
         ST_FLIP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // flips on the local coordinates of the fetched cell
   always_comb begin
      su   = word[FLAG_X_BIT] ? (tw - SIZE_W'(1) - SIZE_W'(rem_x)) : SIZE_W'(rem_x);
      sv   = word[FLAG_Y_BIT] ? (th - SIZE_W'(1) - SIZE_W'(rem_y)) : SIZE_W'(rem_y);
      swap = word[FLAG_D_BIT] & (tw == th);
   end

   // outputs and datapath
   always_comb begin
      req_in        = req_ff;
      clr_in        = clr_ff;
      addr_in       = addr_ff;
      inside_in     = inside_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      mem_waddr     = AW'(32'(req_ff.cell_row) * MAX_COLUMNS + 32'(req_ff.cell_col));
      mem_wdata     = req_ff.cell_word;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
            end
         end
         ST_WRITE: begin
            mem_we          = write_fits;
            rsp_strobe_in   = 1'b1;
            rsp_in.write_ok = write_fits;
         end
         ST_SETUP: begin
            rsp_strobe_in = early_miss;
         end
         ST_CHECK: begin
            inside_in = (quo_x < PIX_W'(cols)) & (quo_y < PIX_W'(rows));
            addr_in   = AW'(32'(quo_y) * MAX_COLUMNS + 32'(quo_x));
         end
         ST_FLIP: begin
            rsp_strobe_in = 1'b1;
            if (inside_ff && (word[INDEX_W-1:0] != '0)) begin
               rsp_in.hit        = 1'b1;
               rsp_in.tile_index = word[INDEX_W-1:0];
               rsp_in.local_u    = swap ? sv[LOCAL_W-1:0] : su[LOCAL_W-1:0];
               rsp_in.local_v    = swap ? su[LOCAL_W-1:0] : sv[LOCAL_W-1:0];
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      addr_ff   <= addr_in;
      inside_ff <= inside_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tpl_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_csr
// APB-style register file holding tile size, grid size and map origin.
// ----------------------------------------------------------------------------
module tpl_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [tpl_pkg::CSR_AW-1:0] paddr,
   input  wire logic [tpl_pkg::CSR_DW-1:0] pwdata,
   output logic      [tpl_pkg::CSR_DW-1:0] prdata,
   output logic                            pready,
   output tpl_pkg::cfg_type                cfg
);
   import tpl_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TILE_WIDTH:   cfg_in.tile_width   = pwdata[SIZE_W-1:0];
            REG_TILE_HEIGHT:  cfg_in.tile_height  = pwdata[SIZE_W-1:0];
            REG_GRID_COLUMNS: cfg_in.grid_columns = pwdata[GRID_W-1:0];
            REG_GRID_ROWS:    cfg_in.grid_rows    = pwdata[GRID_W-1:0];
            REG_ORIGIN_X:     cfg_in.origin_x     = pwdata[PIX_W-1:0];
            REG_ORIGIN_Y:     cfg_in.origin_y     = pwdata[PIX_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_width   <= SIZE_W'(16);
         cfg_ff.tile_height  <= SIZE_W'(16);
         cfg_ff.grid_columns <= GRID_W'(64);
         cfg_ff.grid_rows    <= GRID_W'(64);
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TILE_WIDTH:   prdata = CSR_DW'(cfg_ff.tile_width);
         REG_TILE_HEIGHT:  prdata = CSR_DW'(cfg_ff.tile_height);
         REG_GRID_COLUMNS: prdata = CSR_DW'(cfg_ff.grid_columns);
         REG_GRID_ROWS:    prdata = CSR_DW'(cfg_ff.grid_rows);
         REG_ORIGIN_X:     prdata = CSR_DW'($unsigned(cfg_ff.origin_x));
         REG_ORIGIN_Y:     prdata = CSR_DW'($unsigned(cfg_ff.origin_y));
         default:          prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tpl_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_divider
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpl_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire logic [tpl_pkg::PIX_W-1:0]   dividend,
   input  wire logic [tpl_pkg::SIZE_W-1:0]  divisor,
   output logic                             done,
   output logic      [tpl_pkg::PIX_W-1:0]   quotient,
   output logic      [tpl_pkg::LOCAL_W-1:0] remainder
);
   import tpl_pkg::*;

   localparam int CNT_W = $clog2(PIX_W);

   logic                run_ff, run_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PIX_W-1:0]    shift_ff, shift_in;
   logic [LOCAL_W-1:0]  rem_ff, rem_in;
   logic [SIZE_W-1:0]   div_ff, div_in;
   logic [SIZE_W-1:0]   trial;
   logic [SIZE_W-1:0]   diff;
   logic                fits;
   logic                last;

   // dividend bits leave at the top while quotient bits enter at the bottom
   assign trial = {rem_ff, shift_ff[PIX_W-1]};
   assign fits  = trial >= div_ff;
   assign diff  = trial - div_ff;
   assign last  = count_ff == CNT_W'(PIX_W - 1);

   assign done      = run_ff & last;
   assign quotient  = shift_ff;
   assign remainder = rem_ff;

   always_comb begin
      run_in   = run_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (load) begin
         run_in   = 1'b1;
         count_in = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (run_ff) begin
         count_in = count_ff + CNT_W'(1);
         shift_in = {shift_ff[PIX_W-2:0], fits};
         rem_in   = fits ? diff[LOCAL_W-1:0] : trial[LOCAL_W-1:0];
         if (last) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tpl_cell_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_cell_store
// Cell word memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpl_cell_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [tpl_pkg::WORD_W-1:0] wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [tpl_pkg::WORD_W-1:0] rd_data
);
   import tpl_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire
